// ===== hdl/f2c_pkg.sv =====
// Shared constants, types and helpers for the Frenet-to-Cartesian core.
package f2c_pkg;

    localparam int MaxWaypoints = 256;
    localparam int IdxW = 8;
    localparam int CordicIters = 20;
    localparam int IterW = 5;
    localparam int CordicW = 36;
    localparam logic signed [CordicW-1:0] KinvQ30 = 36'sd652032874;
    localparam logic signed [CordicW-1:0] OneQ30 = 36'sd1073741824;
    localparam logic [8:0] MaxCount = 9'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LOAD_START,
        ST_LOAD_NEXT,
        ST_CORDIC,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_SUM,
        ST_DONE
    } f2c_state_t;

    // Data handed from one rotation cell to the next.
    typedef struct packed {
        logic signed [CordicW-1:0] vx;
        logic signed [CordicW-1:0] vy;
        logic signed [CordicW-1:0] uc;
        logic signed [CordicW-1:0] us;
    } f2c_rot_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        begin
            hi = 68'sd2147483647;
            lo = -68'sd2147483648;
            if (v > hi) sat32 = 32'sh7fffffff;
            else if (v < lo) sat32 = 32'sh80000000;
            else sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== hdl/f2c_cell.sv =====
// One CORDIC micro-rotation cell with its own shift amount.
module f2c_cell (
    input  logic                  clk,
    input  logic                  en,
    input  logic [f2c_pkg::IterW-1:0] shift,
    input  f2c_pkg::f2c_rot_t      din,
    output f2c_pkg::f2c_rot_t      dout
);
    import f2c_pkg::*;

    f2c_rot_t res_reg;
    f2c_rot_t res_next;

    // Rotate toward the x axis by the sign of y.
    always_comb
    begin
        if (din.vy > 0)
        begin
            res_next.vx = din.vx + (din.vy >>> shift);
            res_next.vy = din.vy - (din.vx >>> shift);
            res_next.uc = din.uc - (din.us >>> shift);
            res_next.us = din.us + (din.uc >>> shift);
        end
        else
        begin
            res_next.vx = din.vx - (din.vy >>> shift);
            res_next.vy = din.vy + (din.vx >>> shift);
            res_next.uc = din.uc + (din.us >>> shift);
            res_next.us = din.us - (din.uc >>> shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) res_reg <= res_next;
    end

    assign dout = res_reg;
endmodule

// ===== hdl/f2c_chain.sv =====
// Row of CORDIC cells; a vector enters cell 0 and moves one cell per cycle while en is high.
module f2c_chain (
    input  logic              clk,
    input  logic              en,
    input  f2c_pkg::f2c_rot_t din,
    output f2c_pkg::f2c_rot_t dout
);
    import f2c_pkg::*;

    f2c_rot_t link [CordicIters+1];

    assign link[0] = din;

    for (genvar i = 0; i < CordicIters; i++)
    begin : g_cell
        f2c_cell u_cell (
            .clk  (clk),
            .en   (en),
            .shift(IterW'(i)),
            .din  (link[i]),
            .dout (link[i+1])
        );
    end

    assign dout = link[CordicIters];
endmodule

// ===== hdl/frenet_to_cartesian_core.sv =====
// Top level of the Frenet-to-Cartesian waypoint conversion core.
//
//  channel  | ports                                              | timing
//  ---------+----------------------------------------------------+-------------------
//  command  | start, busy, func, entry_*, query_*                 | start & !busy
//  result   | done, map_east, map_north, segment_start            | one-cycle strobe
//  config   | cfg_we, cfg_data                                    | write at cfg_we
//
// A waypoint write is taken while idle and leaves busy low. A conversion keeps
// busy high while it searches the entries (1 to waypoints_in_use of them) with one
// read each, makes two table reads, runs the cell row and goes through the multiply,
// sum and finish states; the linear search on the single read port sets how long
// this lasts. done is high in the first cycle with busy low again.
// Reset clears control state and sets waypoints_in_use to 1; the tables
// are undefined until written. The receiver cannot stall the result.
module frenet_to_cartesian_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [7:0]         entry_index,
    input  logic signed [31:0] entry_dist,
    input  logic signed [31:0] entry_east,
    input  logic signed [31:0] entry_north,
    input  logic signed [31:0] query_dist,
    input  logic signed [31:0] query_offset,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_data,
    output logic               done,
    output logic signed [31:0] map_east,
    output logic signed [31:0] map_north,
    output logic [7:0]         segment_start
);
    import f2c_pkg::*;

    logic [95:0] tbl [MaxWaypoints];
    logic [95:0] rd_reg;

    f2c_state_t state_reg, state_next;
    logic [8:0] count_reg;
    logic [8:0] n_eff;
    logic [8:0] pos_reg, pos_next;
    logic [IdxW-1:0] start_reg, start_next;
    logic [IdxW-1:0] rd_addr;
    logic [IterW:0] cnt_reg, cnt_next;
    logic signed [31:0] s_reg, d_reg;
    logic signed [31:0] s0_reg, x0_reg, y0_reg;
    logic flip_reg, zero_reg;
    logic signed [CordicW-1:0] cs_reg, sn_reg;
    logic signed [32:0] seg_w;
    logic signed [31:0] cs_lo, sn_lo;
    logic signed [63:0] p_reg;
    logic signed [67:0] acc_reg;
    logic signed [31:0] east_reg, north_reg;
    logic done_reg;
    f2c_rot_t cin, cout;
    logic chain_en;

    assign n_eff = (count_reg == 9'd0) ? 9'd1 :
                   (count_reg > MaxCount) ? MaxCount : count_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) count_reg <= 9'd1;
        else if (cfg_we) count_reg <= cfg_data;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (start && !busy && !func)
            tbl[entry_index] <= {entry_dist, entry_east, entry_north};
        rd_reg <= tbl[rd_addr];
    end

    // Read address per state.
    always_comb
    begin
        case (state_next)
            ST_SEARCH:    rd_addr = pos_next[IdxW-1:0];
            ST_LOAD_START: rd_addr = start_next;
            default:      rd_addr = ((9'(start_reg) + 9'd1) >= n_eff) ? '0 :
                                    start_reg + IdxW'(1);
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        start_next = start_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && func)
                begin
                    state_next = ST_SEARCH;
                    pos_next = 9'd0;
                    start_next = '0;
                end
            end
            ST_SEARCH:
            begin
                // rd_reg holds entry pos_reg.
                if ($signed(s_reg) > $signed(rd_reg[95:64]))
                begin
                    start_next = pos_reg[IdxW-1:0];
                    if (pos_reg + 9'd1 < n_eff) pos_next = pos_reg + 9'd1;
                    else state_next = ST_LOAD_START;
                end
                else state_next = ST_LOAD_START;
            end
            ST_LOAD_START: state_next = ST_LOAD_NEXT;
            ST_LOAD_NEXT:
            begin
                state_next = ST_CORDIC;
                cnt_next = '0;
            end
            ST_CORDIC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (IterW+1)'(CordicIters)) state_next = ST_MUL_A;
            end
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_MUL_C;
            ST_MUL_C: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg <= '0;
            start_reg <= '0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            start_reg <= start_next;
            cnt_reg <= cnt_next;
            done_reg <= (state_reg == ST_DONE);
        end
    end

    // Segment difference enters the cell row with the half-turn fix.
    always_comb
    begin
        logic signed [CordicW-1:0] dx, dy;
        dx = CordicW'($signed(rd_reg[63:32])) - CordicW'(x0_reg);
        dy = CordicW'($signed(rd_reg[31:0])) - CordicW'(y0_reg);
        cin.vx = (dx < 0) ? -dx : dx;
        cin.vy = (dx < 0) ? -dy : dy;
        cin.uc = KinvQ30;
        cin.us = '0;
    end

    assign chain_en = (state_reg == ST_LOAD_NEXT) || (state_reg == ST_CORDIC);

    f2c_chain u_chain (
        .clk (clk),
        .en  (chain_en),
        .din (cin),
        .dout(cout)
    );

    // Multiplier operands: 33-bit segment length and 32-bit Q2.30 heading.
    assign seg_w = 33'(s_reg) - 33'(s0_reg);
    assign cs_lo = cs_reg[31:0];
    assign sn_lo = sn_reg[31:0];

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && func)
        begin
            s_reg <= query_dist;
            d_reg <= query_offset;
        end
        if (state_reg == ST_LOAD_START)
        begin
            s0_reg <= rd_reg[95:64];
            x0_reg <= rd_reg[63:32];
            y0_reg <= rd_reg[31:0];
        end
        case (state_reg)
            ST_MUL_A:
            begin
                if (zero_reg)
                begin
                    cs_reg <= OneQ30;
                    sn_reg <= '0;
                end
                else if (flip_reg)
                begin
                    cs_reg <= -cout.uc;
                    sn_reg <= -cout.us;
                end
                else
                begin
                    cs_reg <= cout.uc;
                    sn_reg <= cout.us;
                end
            end
            ST_MUL_B:
            begin
                p_reg <= 64'(seg_w) * 64'(cs_lo);
            end
            ST_MUL_C:
            begin
                acc_reg <= 68'(p_reg) + 68'sd536870912;
                p_reg <= 64'(d_reg) * 64'(sn_lo);
            end
            ST_MUL_D:
            begin
                east_reg <= sat32(68'(x0_reg) + ((acc_reg + 68'(p_reg)) >>> 30));
                acc_reg <= 68'sd536870912 - 68'(64'(d_reg) * 64'(cs_lo));
                p_reg <= 64'(seg_w) * 64'(sn_lo);
            end
            ST_SUM:
            begin
                north_reg <= sat32(68'(y0_reg) + ((acc_reg + 68'(p_reg)) >>> 30));
            end
            default: ;
        endcase
    end

    // Zero-length and flip flags, taken while the next entry is on the read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD_NEXT)
        begin
            zero_reg <= (rd_reg[63:32] == x0_reg) && (rd_reg[31:0] == y0_reg);
            flip_reg <= ($signed(rd_reg[63:32]) < x0_reg);
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign map_east = east_reg;
    assign map_north = north_reg;
    assign segment_start = start_reg;
endmodule

// ===== test/tb_frenet_to_cartesian_core.sv =====
// Self-checking testbench for the Frenet-to-Cartesian waypoint conversion core.
module tb_frenet_to_cartesian_core;

    // Command kinds carried on func.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;
    localparam int QuietLimit = 4000;
    localparam int DrainCycles = 400;

    typedef struct {
        logic        func;
        logic [7:0]  index;
        logic [31:0] e_dist;
        logic [31:0] e_east;
        logic [31:0] e_north;
        logic [31:0] q_dist;
        logic [31:0] q_offset;
    } command_t;

    typedef struct {
        logic [31:0] east;
        logic [31:0] north;
        logic [7:0]  seg_start;
    } position_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic func = 1'b0;
    logic [7:0] entry_index = '0;
    logic signed [31:0] entry_dist = '0;
    logic signed [31:0] entry_east = '0;
    logic signed [31:0] entry_north = '0;
    logic signed [31:0] query_dist = '0;
    logic signed [31:0] query_offset = '0;
    logic cfg_we = 1'b0;
    logic [8:0] cfg_data = 9'd1;
    logic busy;
    logic done;
    logic signed [31:0] map_east;
    logic signed [31:0] map_north;
    logic [7:0] segment_start;

    command_t pending_cmds[$];
    position_t expected_positions[$];
    int error_count = 0;
    int quiet_cycles = 0;
    int gap_left = 0;
    bit gap_drawn = 1'b0;

    // Predictor state.
    logic signed [31:0] way_dist[256];
    logic signed [31:0] way_east[256];
    logic signed [31:0] way_north[256];
    int unsigned way_count = 1;

    frenet_to_cartesian_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .entry_index(entry_index), .entry_dist(entry_dist), .entry_east(entry_east),
        .entry_north(entry_north), .query_dist(query_dist),
        .query_offset(query_offset), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .map_east(map_east), .map_north(map_north),
        .segment_start(segment_start)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // Heading of a segment as a Q2.30 unit vector by vectoring CORDIC.
    task automatic heading_q30(input logic signed [63:0] dx, input logic signed [63:0] dy,
                               output logic signed [63:0] cs, output logic signed [63:0] sn);
        logic signed [63:0] vx, vy, c, s, t;
        bit flip;
        vx = dx; vy = dy; c = 64'sd652032874; s = 0; flip = 0;
        if (dx == 0 && dy == 0) begin
            cs = 64'sd1073741824;
            sn = 0;
            return;
        end
        if (vx < 0) begin
            vx = -vx; vy = -vy; flip = 1;
        end
        for (int i = 0; i < 20; i++) begin
            if (vy > 0) begin
                t = vx + (vy >>> i); vy = vy - (vx >>> i); vx = t;
                t = c - (s >>> i); s = s + (c >>> i); c = t;
            end else begin
                t = vx - (vy >>> i); vy = vy + (vx >>> i); vx = t;
                t = c + (s >>> i); s = s - (c >>> i); c = t;
            end
        end
        cs = flip ? -c : c;
        sn = flip ? -s : s;
    endtask

    // Apply one command to the predictor and queue the position it yields.
    task automatic predict_position(input command_t cmd);
        int pos, n, first, nxt;
        logic signed [63:0] sq, dq, seg, cs, sn, acc;
        position_t p;
        if (cmd.func == FUNC_WRITE) begin
            way_dist[cmd.index] = cmd.e_dist;
            way_east[cmd.index] = cmd.e_east;
            way_north[cmd.index] = cmd.e_north;
            return;
        end
        n = (way_count < 1) ? 1 : (way_count > 256 ? 256 : way_count);
        sq = $signed(cmd.q_dist);
        dq = $signed(cmd.q_offset);
        pos = -1;
        while (pos + 1 < n && sq > way_dist[pos + 1]) pos++;
        first = (pos < 0) ? 0 : pos;
        nxt = (first + 1 >= n) ? 0 : first + 1;
        heading_q30(64'(way_east[nxt]) - 64'(way_east[first]),
                    64'(way_north[nxt]) - 64'(way_north[first]), cs, sn);
        seg = sq - 64'(way_dist[first]);
        acc = seg * cs + dq * sn + (64'sd1 <<< 29);
        p.east = clamp32(64'(way_east[first]) + (acc >>> 30));
        acc = seg * sn - dq * cs + (64'sd1 <<< 29);
        p.north = clamp32(64'(way_north[first]) + (acc >>> 30));
        p.seg_start = first[7:0];
        expected_positions.insert(expected_positions.size(), p);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 400000)) - 200000;
        endcase
    endfunction

    function automatic command_t make_write(input int idx, input logic [31:0] sd,
                                            input logic [31:0] x, input logic [31:0] y);
        command_t c;
        c = '{FUNC_WRITE, idx[7:0], sd, x, y, $urandom(), $urandom()};
        return c;
    endfunction

    function automatic command_t make_query(input logic [31:0] sq, input logic [31:0] dq);
        command_t c;
        c = '{FUNC_CONVERT, 8'($urandom()), $urandom(), $urandom(), $urandom(), sq, dq};
        return c;
    endfunction

    // Append one command to the driver's queue.
    task automatic add_cmd(input command_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Driver: one command transfer per start & !busy, with a random gap.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                start <= 1'b0;
                gap_drawn <= 1'b0;
            end else if (!start && pending_cmds.size() > 0) begin
                if (!gap_drawn) begin
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                    gap_drawn <= 1'b1;
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else begin
                    command_t c;
                    c = pending_cmds.pop_front();
                    predict_position(c);
                    func <= c.func;
                    entry_index <= c.index;
                    entry_dist <= c.e_dist;
                    entry_east <= c.e_east;
                    entry_north <= c.e_north;
                    query_dist <= c.q_dist;
                    query_offset <= c.q_offset;
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n) begin
            quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
            if (done) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch("unexpected result", map_east, 32'h0);
                end else begin
                    position_t p;
                    p = expected_positions.pop_front();
                    if (map_east !== p.east) report_mismatch("map_east", map_east, p.east);
                    if (map_north !== p.north)
                        report_mismatch("map_north", map_north, p.north);
                    if (segment_start !== p.seg_start)
                        report_mismatch("segment_start", segment_start, p.seg_start);
                end
            end
            if (quiet_cycles >= QuietLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Wait until every queued command is sent and every result checked.
    task automatic drain();
        while (pending_cmds.size() > 0 || start || expected_positions.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_count(input int unsigned n);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= n[8:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        way_count = n;
    endtask

    // Load entries 0..n-1 with a sorted distance table and random points.
    task automatic load_table(input int n, input bit tiny_steps);
        logic signed [31:0] sd;
        sd = -$signed($urandom_range(0, 1 << 22));
        for (int i = 0; i < n; i++) begin
            add_cmd(make_write(i, sd, rand_coord(), rand_coord()));
            sd = sd + (tiny_steps ? $urandom_range(0, 3) : $urandom_range(1, 1 << 20));
        end
    endtask

    task automatic random_queries(input int cnt, input int n);
        logic [31:0] sq;
        for (int k = 0; k < cnt; k++) begin
            case ($urandom_range(0, 4))
                0: sq = $urandom();
                1: sq = way_dist[$urandom_range(0, n - 1)];
                default: sq = way_dist[$urandom_range(0, n - 1)] + $urandom_range(0, 1 << 20) - 1000;
            endcase
            add_cmd(make_query(sq, ($urandom_range(0, 3) == 0) ? $urandom()
                               : $signed($urandom_range(0, 1 << 21)) - (1 << 20)));
        end
    endtask

    initial begin
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single waypoint, zero-length segment, extremes.
        add_cmd(make_write(0, 32'h0, 32'h1000, 32'h2000));
        add_cmd(make_query(32'h80000000, 32'h7fffffff));
        add_cmd(make_query(32'h7fffffff, 32'h80000000));
        add_cmd(make_write(1, 32'h00010000, 32'h7fffffff, 32'h80000000));
        add_cmd(make_write(2, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        add_cmd(make_write(255, 32'h80000000, 32'hffffffff, 32'h0));
        drain();
        // Entries 3 to 254 fill the rest so a full table never reads an unwritten slot.
        for (int i = 3; i < 255; i++)
            add_cmd(make_write(i, 32'h7fffffff, $urandom(), $urandom()));
        set_count(2);
        add_cmd(make_query(32'h0, 32'h0));
        add_cmd(make_query(32'h00020000, 32'hffff0000));
        add_cmd(make_query(32'h80000000, 32'h80000000));
        add_cmd(make_query(32'h7fffffff, 32'h7fffffff));
        set_count(0);
        add_cmd(make_query(32'h00008000, 32'h00010000));
        set_count(511);
        add_cmd(make_query(32'h7fffffff, 32'h1));
        add_cmd(make_query(32'h00010001, 32'h0));
        set_count(256);
        add_cmd(make_query(32'h00000001, 32'hfffffffe));

        // Random phases over several table sizes, small ones most often.
        for (int ph = 0; ph < 14; ph++) begin
            n = (ph % 5 == 4) ? 256 : $urandom_range(1, 12);
            set_count(1);
            load_table(n, ph % 3 == 1);
            set_count(n);
            drain();
            random_queries(n == 256 ? 20 : 70, n);
            for (int k = 0; k < 6; k++)
                add_cmd(make_write($urandom_range(n, 255) % 256,
                    way_dist[n - 1], rand_coord(), rand_coord()));
        end
        drain();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/f2c_pkg.sv
hdl/f2c_cell.sv
hdl/f2c_chain.sv
hdl/frenet_to_cartesian_core.sv
test/tb_frenet_to_cartesian_core.sv
